@@ design/yenc_pkg.sv @@
// shared types, constants and crc helper for the yenc byte encoder
package yenc_pkg;

   localparam int MAX_RESULTS        = 4;
   localparam int RESULT_INDEX_WIDTH = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH        = 4;

   localparam int LINE_LENGTH_WIDTH = 10;
   localparam int COLUMN_WIDTH      = 11;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = LINE_LENGTH_WIDTH;

   localparam logic [LINE_LENGTH_WIDTH-1:0] LINE_LENGTH_RESET = 10'd128;

   localparam logic [7:0]  ENCODE_OFFSET = 8'd42;
   localparam logic [7:0]  ESCAPE_OFFSET = 8'd64;
   localparam logic [7:0]  CHAR_NUL      = 8'h00;
   localparam logic [7:0]  CHAR_LF       = 8'h0a;
   localparam logic [7:0]  CHAR_CR       = 8'h0d;
   localparam logic [7:0]  CHAR_EQUALS   = 8'h3d;
   localparam logic [7:0]  CHAR_DOT      = 8'h2e;
   localparam logic [31:0] CRC_POLY      = 32'hedb88320;

   typedef enum logic [1:0] {
      MODE_BEGIN  = 2'd0,
      MODE_DATA   = 2'd1,
      MODE_CLOSE  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LINE_LENGTH   = 2'd0,
      CSR_DOT_DOUBLING  = 2'd1,
      CSR_LINE_END_CRLF = 2'd2,
      CSR_NONE          = 2'd3
   } csr_index_type;

   // one queued job: the characters an item produces plus close totals
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0]    chars;
      logic [RESULT_INDEX_WIDTH-1:0]  last_index;
      logic                           is_close;
      logic [31:0]                    crc_value;
      logic [31:0]                    byte_total;
   } job_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ design/yenc_front.sv @@
// front end: accepts items, holds csr and running state, builds jobs
module yenc_front
   import yenc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [7:0]                   req_data_byte,
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  logic                         queue_full,
   output logic                         push,
   output job_type                      job
);

   logic [LINE_LENGTH_WIDTH-1:0] line_length_ff;
   logic                         dot_doubling_ff;
   logic                         line_end_crlf_ff;

   logic [COLUMN_WIDTH-1:0] column_ff, column_in;
   logic [31:0]             crc_ff, crc_in;
   logic [31:0]             count_ff, count_in;

   mode_type                mode;
   logic                    accept;
   logic [7:0]              coded;
   logic                    escape;
   logic [7:0]              ch;
   logic [COLUMN_WIDTH-1:0] col_one;
   logic                    dot;
   logic [COLUMN_WIDTH-1:0] col_two;
   logic                    line_end;

   assign mode      = mode_type'(req_mode);
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (mode == MODE_DATA || mode == MODE_CLOSE);

   assign coded    = req_data_byte + ENCODE_OFFSET;
   assign escape   = coded inside {CHAR_NUL, CHAR_LF, CHAR_CR, CHAR_EQUALS};
   assign ch       = escape ? coded + ESCAPE_OFFSET : coded;
   assign col_one  = column_ff + COLUMN_WIDTH'(escape) + COLUMN_WIDTH'(1);
   assign dot      = dot_doubling_ff && (col_one == COLUMN_WIDTH'(1)) && (ch == CHAR_DOT);
   assign col_two  = col_one + COLUMN_WIDTH'(dot);
   assign line_end = col_two >= {1'b0, line_length_ff};

   always_comb begin
      logic [RESULT_INDEX_WIDTH:0] slot;
      slot           = '0;
      job            = '0;
      if (mode == MODE_DATA) begin
         if (escape) begin
            job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = CHAR_EQUALS;
            slot = slot + 1'b1;
         end
         job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = ch;
         slot = slot + 1'b1;
         if (dot) begin
            job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = ch;
            slot = slot + 1'b1;
         end
         if (line_end) begin
            if (line_end_crlf_ff) begin
               job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = CHAR_CR;
               slot = slot + 1'b1;
            end
            job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = CHAR_LF;
            slot = slot + 1'b1;
         end
      end else begin
         job.is_close   = 1'b1;
         job.crc_value  = ~crc_ff;
         job.byte_total = count_ff;
         if (column_ff != '0) begin
            if (line_end_crlf_ff) begin
               job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = CHAR_CR;
               slot = slot + 1'b1;
            end
            job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = CHAR_LF;
            slot = slot + 1'b1;
         end
         job.chars[slot[RESULT_INDEX_WIDTH-1:0]] = CHAR_NUL;
         slot = slot + 1'b1;
      end
      job.last_index = RESULT_INDEX_WIDTH'(slot - 1'b1);
   end

   always_comb begin
      column_in = column_ff;
      crc_in    = crc_ff;
      count_in  = count_ff;
      if (accept) begin
         case (mode)
            MODE_BEGIN: begin
               column_in = '0;
               crc_in    = '1;
               count_in  = '0;
            end
            MODE_DATA: begin
               column_in = line_end ? '0 : col_two;
               crc_in    = crc_byte(crc_ff, req_data_byte);
               count_in  = count_ff + 32'd1;
            end
            MODE_CLOSE: begin
               column_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         crc_ff    <= '1;
         count_ff  <= '0;
      end else begin
         column_ff <= column_in;
         crc_ff    <= crc_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff   <= LINE_LENGTH_RESET;
         dot_doubling_ff  <= 1'b1;
         line_end_crlf_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_LINE_LENGTH:   line_length_ff   <= csr_write_data;
            CSR_DOT_DOUBLING:  dot_doubling_ff  <= csr_write_data[0];
            CSR_LINE_END_CRLF: line_end_crlf_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

endmodule

@@ design/yenc_queue.sv @@
// job queue between front end and output sequencer
module yenc_queue
   import yenc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    rd_valid,
   output job_type rd_data
);

   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   job_type                 mem [DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;

   assign full     = count_ff == COUNT_WIDTH'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en)
      else $error("queue written while full");

   a_no_read_when_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_valid)
      else $error("queue popped while empty");

   a_count_pop: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !wr_en) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");

endmodule

@@ design/yenc_back.sv @@
// output sequencer: walks each job one character per transfer
module yenc_back
   import yenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [31:0] rsp_crc_value,
   output logic [31:0] rsp_byte_total
);

   logic [RESULT_INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    out_byte_ff;
   logic                          byte_valid_ff;
   logic                          last_ff;
   logic [31:0]                   crc_value_ff;
   logic [31:0]                   byte_total_ff;
   logic                          load;
   logic                          head_last;

   assign head_last = idx_ff == head.last_index;
   assign load      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop       = load && head_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in       = head_last ? '0 : idx_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff   <= head.chars[idx_ff];
         byte_valid_ff <= !(head.is_close && head_last);
         last_ff       <= head_last;
         crc_value_ff  <= head.crc_value;
         byte_total_ff <= head.byte_total;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_last       = last_ff;
   assign rsp_crc_value  = crc_value_ff;
   assign rsp_byte_total = byte_total_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff <= head.last_index)
      else $error("result index past end of job");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == '0)
      else $error("result index not cleared while queue empty");

endmodule

@@ design/yenc_byte_encoder_top.sv @@
// top level of the yenc byte encoder with crc-32 and byte count
// path: an accepted item is written into the job queue, then its characters are loaded into the output register
// throughput: one item per cycle while the four-entry job queue has room
// output runs one result per cycle while rsp_ready is high; escapes, doubled dots and line ends add results to an item
// reset: synchronous, clears queue, state and output valid; csr to 128, 1, 1
module yenc_byte_encoder_top
   import yenc_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic [7:0]                  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_last,
   output logic [31:0]                 rsp_crc_value,
   output logic [31:0]                 rsp_byte_total,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_write_data
);

   logic    queue_full;
   logic    push;
   job_type job;
   logic    head_valid;
   job_type head;
   logic    pop;

   yenc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .job              (job)
   );

   yenc_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push),
      .wr_data  (job),
      .full     (queue_full),
      .rd_en    (pop),
      .rd_valid (head_valid),
      .rd_data  (head)
   );

   yenc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_crc_value  (rsp_crc_value),
      .rsp_byte_total (rsp_byte_total)
   );

endmodule

@@ bench/tb_top.sv @@
// testbench for yenc_byte_encoder_top: encoded stream, line ends, crc and count checked
module tb_top;
   import yenc_pkg::*;

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET    = 220;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [7:0]  ADD_OFFSET = 8'd42;
   localparam logic [7:0]  ESC_OFFSET = 8'd64;
   localparam logic [7:0]  CH_NUL     = 8'h00;
   localparam logic [7:0]  CH_LF      = 8'h0a;
   localparam logic [7:0]  CH_CR      = 8'h0d;
   localparam logic [7:0]  CH_EQUALS  = 8'h3d;
   localparam logic [7:0]  CH_DOT     = 8'h2e;
   localparam logic [31:0] CRC32_POLY = 32'hedb88320;

   // raw bytes that encode to a character needing an escape, or to a dot
   localparam logic [7:0] RAW_TO_NUL    = 8'd214;
   localparam logic [7:0] RAW_TO_LF     = 8'd224;
   localparam logic [7:0] RAW_TO_CR     = 8'd227;
   localparam logic [7:0] RAW_TO_EQUALS = 8'd19;
   localparam logic [7:0] RAW_TO_DOT    = 8'd4;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [31:0] crc_value;
      logic [31:0] byte_total;
   } yenc_char_type;

   class yenc_scoreboard;
      logic [LINE_LENGTH_WIDTH-1:0] line_length;
      logic                         dot_doubling;
      logic                         line_end_crlf;
      logic [COLUMN_WIDTH-1:0]      column;
      logic [31:0]                  crc_reg;
      logic [31:0]                  byte_count;
      logic [7:0]                   item_chars[MAX_RESULTS];
      int                           item_count;
      yenc_char_type                expected_chars[$];
      int                           failures;

      function new();
         line_length   = LINE_LENGTH_RESET;
         dot_doubling  = 1'b1;
         line_end_crlf = 1'b1;
         column        = '0;
         crc_reg       = '1;
         byte_count    = '0;
         failures      = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_LINE_LENGTH:   line_length = value;
            CSR_DOT_DOUBLING:  dot_doubling = value[0];
            CSR_LINE_END_CRLF: line_end_crlf = value[0];
            default: ;
         endcase
      endfunction

      function void add_char(logic [7:0] c);
         item_chars[item_count] = c;
         item_count++;
      endfunction

      function void add_line_end();
         if (line_end_crlf) add_char(CH_CR);
         add_char(CH_LF);
         column = '0;
      endfunction

      // works out the characters one accepted item produces
      function void encode_item(mode_type mode, logic [7:0] raw);
         logic [7:0]    c;
         logic [31:0]   crc_out;
         logic [31:0]   total_out;
         logic          is_close;
         yenc_char_type entry;
         item_count = 0;
         crc_out    = '0;
         total_out  = '0;
         is_close   = 1'b0;
         case (mode)
            MODE_BEGIN: begin
               column     = '0;
               crc_reg    = '1;
               byte_count = '0;
            end
            MODE_DATA: begin
               c = raw + ADD_OFFSET;
               if (c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_EQUALS) begin
                  add_char(CH_EQUALS);
                  c = c + ESC_OFFSET;
                  column++;
               end
               add_char(c);
               column++;
               if (dot_doubling && column == 1 && c == CH_DOT) begin
                  add_char(c);
                  column++;
               end
               if (column >= line_length) add_line_end();
               for (int k = 0; k < 8; k++) begin
                  crc_reg = (crc_reg >> 1) ^ (CRC32_POLY & {32{crc_reg[0] ^ raw[k]}});
               end
               byte_count++;
            end
            MODE_CLOSE: begin
               is_close  = 1'b1;
               crc_out   = ~crc_reg;
               total_out = byte_count;
               if (column != 0) add_line_end();
               add_char(CH_NUL);
               column = '0;
            end
            default: ;
         endcase
         for (int i = 0; i < item_count; i++) begin
            entry.out_byte   = item_chars[i];
            entry.byte_valid = !(is_close && i == item_count - 1);
            entry.last       = (i == item_count - 1);
            entry.crc_value  = crc_out;
            entry.byte_total = total_out;
            expected_chars.push_back(entry);
         end
      endfunction

      function void check_char(yenc_char_type got);
         yenc_char_type want;
         if (expected_chars.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: byte %02h valid %0b last %0b crc %08h total %0d",
                        got.out_byte, got.byte_valid, got.last, got.crc_value, got.byte_total);
            return;
         end
         want = expected_chars.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("mismatch: expected byte %02h valid %0b last %0b crc %08h total %0d",
                        want.out_byte, want.byte_valid, want.last, want.crc_value,
                        want.byte_total);
               $display("          got      byte %02h valid %0b last %0b crc %08h total %0d",
                        got.out_byte, got.byte_valid, got.last, got.crc_value, got.byte_total);
            end
         end
      endfunction

      function void report_leftovers();
         if (expected_chars.size() != 0) begin
            failures += expected_chars.size();
            $display("%0d expected results never arrived", expected_chars.size());
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_mode         = MODE_BEGIN;
   logic [7:0]                 req_data_byte    = 8'd0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [7:0]                 rsp_out_byte;
   logic                       rsp_byte_valid;
   logic                       rsp_last;
   logic [31:0]                rsp_crc_value;
   logic [31:0]                rsp_byte_total;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = CSR_LINE_LENGTH;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   yenc_scoreboard sb;
   bit             send_calm   = 1'b0;
   bit             rsp_calm    = 1'b0;
   int             items_sent  = 0;
   int             quiet_cycles = 0;

   yenc_byte_encoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_crc_value    (rsp_crc_value),
      .rsp_byte_total   (rsp_byte_total),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic logic [7:0] pick_raw();
      if ($urandom_range(0, 99) < 20) begin
         case ($urandom_range(0, 4))
            0:       return RAW_TO_NUL;
            1:       return RAW_TO_LF;
            2:       return RAW_TO_CR;
            3:       return RAW_TO_EQUALS;
            default: return RAW_TO_DOT;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_item(mode_type mode, logic [7:0] data);
      int gap;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      sb.encode_item(mode, data);
      if (mode != MODE_UNUSED) items_sent++;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(logic [LINE_LENGTH_WIDTH-1:0] line_len, bit dot, bit crlf);
      write_reg(CSR_LINE_LENGTH, line_len);
      write_reg(CSR_DOT_DOUBLING, CSR_DATA_WIDTH'(dot));
      write_reg(CSR_LINE_END_CRLF, CSR_DATA_WIDTH'(crlf));
   endtask

   // result side: random stalls, every transfer checked
   initial begin
      int            stall_left;
      yenc_char_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.out_byte   = rsp_out_byte;
            got.byte_valid = rsp_byte_valid;
            got.last       = rsp_last;
            got.crc_value  = rsp_crc_value;
            got.byte_total = rsp_byte_total;
            sb.check_char(got);
         end
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = pick_gap(rsp_calm);
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int                           phase;
      int                           parts;
      int                           part_len;
      int                           hold_at;
      logic [LINE_LENGTH_WIDTH-1:0] line_len;
      sb    = new();
      phase = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: escapes, dot in first column, ignored mode, closes
      send_item(MODE_BEGIN, 8'hff);
      send_item(MODE_DATA, RAW_TO_DOT);
      send_item(MODE_DATA, RAW_TO_NUL);
      send_item(MODE_DATA, RAW_TO_LF);
      send_item(MODE_DATA, RAW_TO_CR);
      send_item(MODE_DATA, RAW_TO_EQUALS);
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_DATA, 8'hff);
      send_item(MODE_UNUSED, 8'hff);
      send_item(MODE_CLOSE, 8'h00);
      send_item(MODE_CLOSE, 8'hff);
      send_item(MODE_DATA, RAW_TO_DOT);
      send_item(MODE_CLOSE, 8'h00);

      // one-character lines, no doubling, lf only; data with no begin
      wait_for_results();
      configure(10'd1, 1'b0, 1'b0);
      send_item(MODE_DATA, RAW_TO_DOT);
      send_item(MODE_DATA, RAW_TO_NUL);
      send_item(MODE_CLOSE, 8'h00);

      // zero line length: line end after every character
      wait_for_results();
      configure(10'd0, 1'b1, 1'b1);
      send_item(MODE_BEGIN, 8'h00);
      send_item(MODE_DATA, RAW_TO_DOT);
      send_item(MODE_DATA, RAW_TO_CR);
      send_item(MODE_CLOSE, 8'h00);

      // longest lines
      wait_for_results();
      configure(10'd1023, 1'b1, 1'b0);
      send_item(MODE_BEGIN, 8'h00);
      send_item(MODE_DATA, 8'hff);
      send_item(MODE_DATA, RAW_TO_DOT);
      send_item(MODE_CLOSE, 8'h00);

      while (items_sent < ITEM_TARGET) begin
         wait_for_results();
         case (phase % 4)
            0:       line_len = LINE_LENGTH_WIDTH'($urandom_range(1, 6));
            1:       line_len = LINE_LENGTH_WIDTH'($urandom_range(7, 40));
            2:       line_len = (phase % 8 == 2) ? 10'd1023 : 10'd1;
            default: line_len = LINE_LENGTH_WIDTH'($urandom_range(1, 1023));
         endcase
         configure(line_len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         send_calm = (phase % 4 == 1) || ($urandom_range(0, 4) == 0);
         rsp_calm  = (phase % 4 == 1) || ($urandom_range(0, 4) == 0);
         parts     = int'($urandom_range(1, 3));
         for (int p = 0; p < parts; p++) begin
            part_len = int'($urandom_range(2, 18));
            hold_at  = (p == 0) ? int'($urandom_range(0, part_len - 1)) : -1;
            if ($urandom_range(0, 9) != 0) send_item(MODE_BEGIN, 8'($urandom));
            for (int k = 0; k < part_len; k++) begin
               if (k == hold_at) wait_for_results();
               if ($urandom_range(0, 19) == 0) send_item(MODE_UNUSED, 8'($urandom));
               send_item(MODE_DATA, pick_raw());
            end
            if ($urandom_range(0, 9) != 0) send_item(MODE_CLOSE, 8'($urandom));
            if ($urandom_range(0, 14) == 0) send_item(MODE_CLOSE, 8'($urandom));
         end
         phase++;
      end

      wait_for_results();
      sb.report_leftovers();
      if (sb.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures", sb.failures);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/yenc_pkg.sv
design/yenc_front.sv
design/yenc_queue.sv
design/yenc_back.sv
design/yenc_byte_encoder_top.sv
bench/tb_top.sv
